// ===== hw/rtl/nsm_pkg.sv =====
// ----------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants for the non-overlapping substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package nsm_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned KEY_SLOTS = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned OUT_IDX_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  key_len_t;

  // Per-cycle control broadcast to every window cell
  typedef struct packed {
    logic advance;  // a character transfer shifts the window
    logic clear;    // restart the window after a match or at string end
  } cell_ctrl_t;

endpackage : nsm_pkg

`default_nettype wire

// ===== hw/rtl/nsm_cell.sv =====
// ----------------------------------------------------------------------------
// nsm_cell
// One window position: holds a character and its fill flag, hands both to
// the next cell on every transfer and compares the incoming character with
// the keyword character that aligns with this position.
// ----------------------------------------------------------------------------
`default_nettype none

module nsm_cell
  import nsm_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire char_t      key_chars [KEY_SLOTS],
  input  wire key_len_t   key_len,
  input  wire char_t      char_in,
  input  wire logic       valid_in,
  output char_t           char_r,
  output logic            valid_r,
  output logic            cell_ok
);

  char_t    char_nxt;
  logic     valid_nxt;
  key_len_t slot_sel;

  // Position POS of the window meets keyword character key_len-1-POS
  assign slot_sel = key_len_t'(key_len - key_len_t'(POS) - key_len_t'(1));

  always_comb begin
    if (key_len_t'(POS) < key_len) begin
      cell_ok = valid_in && (char_in == key_chars[slot_sel[SLOT_W-1:0]]);
    end else begin
      cell_ok = 1'b1;
    end
  end

  assign char_nxt  = ctrl.advance ? char_in : char_r;
  assign valid_nxt = ctrl.advance ? (valid_in && !ctrl.clear) : valid_r;

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule : nsm_cell

`default_nettype wire

// ===== hw/rtl/nonoverlap_substring_match.sv =====
// ----------------------------------------------------------------------------
// nonoverlap_substring_match
// Streaming keyword search over text strings; matches never overlap.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// in_      | slave     | tdata: text_char[7:0]; tlast: string_last
// out_     | master    | tdata: start_idx, end_index, string_had_match;
//          |           | tuser: match_found; tlast: string_done
// cfg_     | write     | key_chars_low, key_chars_high, key_length
//
// One character per cycle. A row of window cells compares the whole window
// in the cycle of the transfer; the result is registered at the transfer edge
// and offered from the next cycle. The input stalls only while that register
// holds a result that has not been taken. Reset (synchronous) empties the
// window and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module nonoverlap_substring_match
  import nsm_pkg::*;
#(
  parameter int unsigned MAX_KEY_LEN = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [CHAR_W-1:0]    in_tdata,   // [7:0] text_char
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // [15:0] start_idx,
                                                // [31:16] end_index,
                                                // [32] string_had_match
  output logic                      out_tuser,  // [0] match_found
  output logic                      out_tlast,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam key_len_t MAX_LEN = key_len_t'(MAX_KEY_LEN);

  typedef struct packed {
    logic                 match_found;
    logic [OUT_IDX_W-1:0] start_idx;
    logic [OUT_IDX_W-1:0] end_index;
    logic                 string_done;
    logic                 string_had_match;
  } result_t;

  // Configuration
  logic [CFG_W-1:0] key_low_r, key_high_r;
  key_len_t         key_len_r;
  char_t            key_chars [KEY_SLOTS];
  key_len_t         len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LEN:  key_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < KEY_SLOTS / 2; k++) begin
      key_chars[k]                 = key_low_r[k*CHAR_W +: CHAR_W];
      key_chars[k + KEY_SLOTS / 2] = key_high_r[k*CHAR_W +: CHAR_W];
    end
  end

  assign len_eff = (key_len_r > MAX_LEN) ? MAX_LEN : key_len_r;

  // Handshake and control
  logic       in_xfer;
  logic       hit;
  cell_ctrl_t ctrl;
  result_t    res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready    = !out_valid_r || out_tready;
  assign in_xfer      = in_tvalid && in_tready;
  assign ctrl.advance = in_xfer;
  assign ctrl.clear   = hit || in_tlast;

  // Window cells
  char_t                  win_char  [MAX_KEY_LEN];
  logic                   win_valid [MAX_KEY_LEN];
  logic [MAX_KEY_LEN-1:0] cell_ok;

  for (genvar g = 0; g < MAX_KEY_LEN; g++) begin : g_cell
    char_t cin;
    logic  vin;
    if (g == 0) begin : g_head
      assign cin = in_tdata;
      assign vin = 1'b1;
    end else begin : g_link
      assign cin = win_char[g-1];
      assign vin = win_valid[g-1];
    end
    nsm_cell #(
      .POS (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .key_chars (key_chars),
      .key_len   (len_eff),
      .char_in   (cin),
      .valid_in  (vin),
      .char_r    (win_char[g]),
      .valid_r   (win_valid[g]),
      .cell_ok   (cell_ok[g])
    );
  end

  assign hit = (len_eff != '0) && (&cell_ok);

  // String position and match history
  logic [INDEX_WIDTH-1:0] pos_r, pos_nxt;
  logic                   any_match_r, any_match_nxt;
  logic [31:0]            start_full;

  assign start_full = 32'(pos_r) - 32'(len_eff) + 32'd1;

  always_comb begin
    pos_nxt       = pos_r;
    any_match_nxt = any_match_r;
    if (in_xfer) begin
      if (in_tlast) begin
        pos_nxt       = '0;
        any_match_nxt = 1'b0;
      end else begin
        if (pos_r != '1) begin
          pos_nxt = pos_r + INDEX_WIDTH'(1);
        end
        if (hit) begin
          any_match_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_nxt                  = res_r;
    out_valid_nxt            = out_valid_r && !out_tready;
    if (in_xfer && (hit || in_tlast)) begin
      out_valid_nxt            = 1'b1;
      res_nxt.match_found      = hit;
      res_nxt.start_idx        = hit ? start_full[OUT_IDX_W-1:0] : '0;
      res_nxt.end_index        = hit ? OUT_IDX_W'(32'(pos_r)) : '0;
      res_nxt.string_done      = in_tlast;
      res_nxt.string_had_match = in_tlast && (any_match_r || hit);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      pos_r       <= '0;
      any_match_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      any_match_r <= any_match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.match_found;
  assign out_tlast  = res_r.string_done;
  assign out_tdata  = {7'd0, res_r.string_had_match, res_r.end_index, res_r.start_idx};

endmodule : nonoverlap_substring_match

`default_nettype wire

// ===== hw/rtl/nsm_checker.sv =====
// ----------------------------------------------------------------------------
// nsm_checker
// Port-level checks on the result stream of the substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module nsm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result without a match must close a string
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("result with neither match nor string end");

  // Indexes read zero when there is no match
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("index nonzero without match");

  // Match history only reported at string end, and always set by a final match
  a_had_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32] == 1'b0 || out_tlast == 1'b1)
      && (!(out_tuser && out_tlast) || out_tdata[32] == 1'b1))
    else $error("inconsistent string_had_match");

endmodule : nsm_checker

bind nonoverlap_substring_match nsm_checker u_nsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== dv/nsm_hit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nsm_hit_checker
// Watches the text, result and register channels of the substring matcher,
// predicts every match and string-close result, and compares each result
// transfer field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module nsm_hit_checker
  import nsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  char_t                in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   n_hits,
  output int                   n_strings
);

  typedef struct packed {
    logic        found;
    logic [15:0] first_idx;
    logic [15:0] last_idx;
    logic        closes;
    logic        had_any;
  } scan_result_t;

  scan_result_t   results_due[$];
  char_t          window [KEY_SLOTS];
  logic [63:0]    key_lo;
  logic [63:0]    key_hi;
  key_len_t       key_len;
  int unsigned    fresh;
  logic [15:0]    pos;
  logic           seen_hit;

  initial begin
    errors    = 0;
    pending   = 0;
    n_hits    = 0;
    n_strings = 0;
  end

  function automatic char_t key_byte(input int k);
    logic [63:0] word;
    word = (k < 8) ? key_lo : key_hi;
    return char_t'(word >> ((k % 8) * 8));
  endfunction

  task automatic scan_char(input char_t c, input logic fin);
    int unsigned  span;
    logic         hit;
    scan_result_t r;
    int           k;
    span = (key_len > KEY_SLOTS) ? KEY_SLOTS : key_len;
    for (k = KEY_SLOTS - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = c;
    if (fresh < KEY_SLOTS) fresh++;
    hit = (span > 0) && (fresh >= span);
    // keyword character 0 sits oldest in the window
    for (k = 0; k < int'(span); k++) begin
      if (key_byte(k) != window[span-1-k]) hit = 1'b0;
    end
    r = '0;
    if (hit) begin
      r.found     = 1'b1;
      r.last_idx  = pos;
      r.first_idx = pos - 16'(span - 1);
      fresh       = 0;
      seen_hit    = 1'b1;
      n_hits++;
    end
    if (pos != 16'hFFFF) pos++;
    if (hit || fin) begin
      r.closes    = fin;
      r.had_any   = fin & seen_hit;
      results_due = {results_due, r};
    end
    if (fin) begin
      pos      = '0;
      fresh    = 0;
      seen_hit = 1'b0;
      n_strings++;
    end
  endtask

  task automatic check_result();
    scan_result_t got;
    scan_result_t want;
    got.found     = out_tuser;
    got.first_idx = out_tdata[15:0];
    got.last_idx  = out_tdata[31:16];
    got.had_any   = out_tdata[32];
    got.closes    = out_tlast;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] unexpected result: found=%0b first=%0d last=%0d done=%0b had=%0b",
                 $realtime, got.found, got.first_idx, got.last_idx, got.closes, got.had_any);
    end else begin
      want = results_due.pop_front();
      if (want.found !== got.found || want.first_idx !== got.first_idx ||
          want.last_idx !== got.last_idx || want.closes !== got.closes ||
          want.had_any !== got.had_any) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] result mismatch: want found=%0b first=%0d last=%0d done=%0b had=%0b",
                   $realtime, want.found, want.first_idx, want.last_idx, want.closes,
                   want.had_any);
          $display("[%0t]                   got found=%0b first=%0d last=%0d done=%0b had=%0b",
                   $realtime, got.found, got.first_idx, got.last_idx, got.closes,
                   got.had_any);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_lo   = '0;
      key_hi   = '0;
      key_len  = '0;
      fresh    = 0;
      pos      = '0;
      seen_hit = 1'b0;
      foreach (window[k]) window[k] = '0;
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_KEY_LOW:  key_lo  = cfg_wdata;
          CFG_KEY_HIGH: key_hi  = cfg_wdata;
          CFG_KEY_LEN:  key_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      // results trail their characters, so retire before predicting
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) scan_char(in_tdata, in_tlast);
    end
    pending = results_due.size();
  end

endmodule : nsm_hit_checker

// ===== dv/tb_nonoverlap_substring_match.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nonoverlap_substring_match
// Drives text strings and keyword settings into the substring matcher: a
// directed opening, then random strings built around the keyword under
// several idle/stall mixes.
// ----------------------------------------------------------------------------

module tb_nonoverlap_substring_match;
  import nsm_pkg::*;

  localparam int LIMIT       = 600000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  char_t                in_tdata   = '0;   // [7:0] text_char
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // [15:0] start, [31:16] end, [32] had_match
  logic                 out_tuser;         // [0] match_found
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int          errors;
  int          pending;
  int          n_hits;
  int          n_strings;
  int          n_sent         = 0;
  int          cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  bit          hold_taken     = 1'b0;
  int          hold_left      = 0;
  logic [63:0] key_lo_set     = '0;
  logic [63:0] key_hi_set     = '0;
  int          key_len_set    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nonoverlap_substring_match u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  nsm_hit_checker u_hit_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .n_hits     (n_hits),
    .n_strings  (n_strings)
  );

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_KEY_LOW:  key_lo_set  = val;
      CFG_KEY_HIGH: key_hi_set  = val;
      CFG_KEY_LEN:  key_len_set = int'(val[LEN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi, input int len);
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LEN, 64'(len));
  endtask

  // Stop offering, wait out every due result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_char(input char_t c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  function automatic char_t key_byte(input int k);
    logic [63:0] word;
    word = (k < 8) ? key_lo_set : key_hi_set;
    return char_t'(word >> ((k % 8) * 8));
  endfunction

  function automatic char_t noise_char();
    if ($urandom_range(99) < 75) return char_t'(8'h41 + $urandom_range(0, 3));
    return char_t'($urandom_range(0, 255));
  endfunction

  // Whole keywords in noise; some cut short or with one char flipped
  task automatic send_string(input int pieces);
    char_t txt[$];
    int    ulen;
    int    r;
    int    cut;
    int    j;
    ulen = (key_len_set > KEY_SLOTS) ? KEY_SLOTS : key_len_set;
    repeat (pieces) begin
      r = $urandom_range(99);
      if (ulen > 0 && r < 40) begin
        for (j = 0; j < ulen; j++) txt = {txt, key_byte(j)};
      end else if (ulen > 1 && r < 55) begin
        cut = $urandom_range(1, ulen - 1);
        for (j = 0; j < cut; j++) txt = {txt, key_byte(j)};
      end else if (ulen > 0 && r < 62) begin
        cut = $urandom_range(0, ulen - 1);
        for (j = 0; j < ulen; j++)
          txt = {txt, (j == cut) ? key_byte(j) ^ char_t'(1 << $urandom_range(0, 7))
                                 : key_byte(j)};
      end else begin
        repeat ($urandom_range(1, 4)) txt = {txt, noise_char()};
      end
    end
    for (j = 0; j < txt.size(); j++) send_char(txt[j], j == txt.size() - 1);
  endtask

  task automatic random_key();
    logic [63:0] lo;
    logic [63:0] hi;
    int          r;
    int          len;
    r = $urandom_range(99);
    if (r < 10)      len = 0;
    else if (r < 20) len = KEY_SLOTS;
    else if (r < 28) len = $urandom_range(17, 31);
    else if (r < 40) len = $urandom_range(7, 15);
    else             len = $urandom_range(1, 6);
    for (int b = 0; b < 8; b++) begin
      lo[b*8 +: 8] = noise_char();
      hi[b*8 +: 8] = noise_char();
    end
    load_key(lo, hi, len);
  endtask

  initial begin
    int send_mix [4];
    int recv_mix [4];
    int mark;
    send_mix = '{0, 48, 0, 16};
    recv_mix = '{0, 0, 48, 16};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero-length keyword: nothing matches, string still closes
    send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b1);
    drain();

    // Overlapping occurrences collapse; match lands on the last char too
    load_key(64'h4141, 64'h0, 2);
    repeat (4) send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b1);
    repeat (3) send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b1);
    drain();

    // Full-width keyword spanning both key registers, extreme char values
    load_key(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, KEY_SLOTS);
    repeat (8) send_char(8'h00, 1'b0);
    repeat (7) send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    drain();

    // Output held off while one-char hits pile up behind it
    load_key(64'h41, 64'h0, 1);
    hold_req <= 1'b1;
    repeat (23) send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct <= recv_mix[p];
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        random_key();
        mark = n_sent;
        while (n_sent - mark < 95) send_string($urandom_range(1, 6));
      end
    end

    drain();
    repeat (2) @(posedge clk);
    $display("Scanned %0d characters in %0d strings; %0d keyword hits predicted and checked.",
             n_sent, n_strings, n_hits);
    $display("Keyword lengths 0 to 31, output hold-off and idle mixes.");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_nonoverlap_substring_match

// ===== nonoverlap_substring_match.f =====
hw/rtl/nsm_pkg.sv
hw/rtl/nsm_cell.sv
hw/rtl/nonoverlap_substring_match.sv
hw/rtl/nsm_checker.sv
dv/nsm_hit_checker.sv
dv/tb_nonoverlap_substring_match.sv
